// ===== rtl/slfr_pkg.sv =====
// Shared types and constants for the sync-byte, length-prefixed frame receiver.
`timescale 1ns / 1ps

package slfr_pkg;

    localparam int unsigned HeaderBytes = 6;
    localparam int unsigned CrcBytes    = 2;

    localparam logic [7:0]  SyncReset    = 8'd170;
    localparam logic [15:0] TimeoutReset = 16'd100;
    localparam logic [15:0] WindowReset  = 16'd100;
    localparam logic [15:0] MaxPayReset  = 16'd1016;

    localparam logic [1:0] CFG_SYNC    = 2'd0;
    localparam logic [1:0] CFG_TIMEOUT = 2'd1;
    localparam logic [1:0] CFG_WINDOW  = 2'd2;
    localparam logic [1:0] CFG_MAXPAY  = 2'd3;

    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    typedef enum logic [1:0] {
        ST_FRAME_BYTE = 2'd0,
        ST_BYTE_TMO   = 2'd1,
        ST_WINDOW_TMO = 2'd2,
        ST_TOO_LONG   = 2'd3
    } status_t;

    typedef struct packed {
        logic       action;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  data_byte;
        logic [16:0] position;
        logic [15:0] payload_length;
        logic [15:0] frame_crc;
        logic        is_last;
    } result_t;

    typedef struct packed {
        logic [7:0]  sync_value;
        logic [15:0] byte_timeout_ticks;
        logic [15:0] frame_window_ticks;
        logic [15:0] max_payload;
    } cfg_t;

endpackage

// ===== rtl/slfr_in_stage.sv =====
// Input register that holds one accepted request until the core takes it.
`timescale 1ns / 1ps

module slfr_in_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_ready,
    input  slfr_pkg::item_t item,
    input  logic            take,
    output logic            held_valid,
    output slfr_pkg::item_t held_item
);

    logic            valid_reg;
    logic            valid_next;
    slfr_pkg::item_t item_reg;

    assign item_ready = !valid_reg || take;
    assign valid_next = item_valid || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

// ===== rtl/slfr_core.sv =====
// Frame state and the single-pass update that turns one request into at most one result.
`timescale 1ns / 1ps

module slfr_core (
    input  logic              clk,
    input  logic              rst_n,
    input  slfr_pkg::cfg_t    cfg,
    input  logic              advance,
    input  slfr_pkg::item_t   item,
    output logic              has_result,
    output slfr_pkg::result_t result
);

    logic        in_frame_reg;
    logic        in_frame_next;
    logic [16:0] byte_count_reg;
    logic [16:0] byte_count_next;
    logic [15:0] length_word_reg;
    logic [15:0] length_word_next;
    logic [7:0]  crc_low_reg;
    logic [7:0]  crc_low_next;
    logic [15:0] idle_ticks_reg;
    logic [15:0] idle_ticks_next;
    logic [15:0] frame_ticks_reg;
    logic [15:0] frame_ticks_next;

    logic [16:0] idle_inc;
    logic [16:0] frame_inc;
    logic [15:0] plen_now;
    logic [15:0] full_length;
    logic [16:0] crc_low_pos;
    logic [16:0] crc_high_pos;
    logic        hunt_reset;

    assign idle_inc     = {1'b0, idle_ticks_reg} + 17'd1;
    assign frame_inc    = {1'b0, frame_ticks_reg} + 17'd1;
    assign plen_now     = (byte_count_reg >= 17'(slfr_pkg::HeaderBytes)) ?
                          length_word_reg : 16'd0;
    assign full_length  = {item.rx_byte, length_word_reg[7:0]};
    assign crc_low_pos  = {1'b0, length_word_reg} + 17'(slfr_pkg::HeaderBytes);
    assign crc_high_pos = crc_low_pos + 17'd1;

    always_comb
    begin
        in_frame_next    = in_frame_reg;
        byte_count_next  = byte_count_reg;
        length_word_next = length_word_reg;
        crc_low_next     = crc_low_reg;
        idle_ticks_next  = idle_ticks_reg;
        frame_ticks_next = frame_ticks_reg;
        hunt_reset       = 1'b0;
        has_result       = 1'b0;

        result.status         = slfr_pkg::ST_FRAME_BYTE;
        result.data_byte      = item.rx_byte;
        result.position       = byte_count_reg;
        result.payload_length = 16'd0;
        result.frame_crc      = 16'd0;
        result.is_last        = 1'b0;

        if (item.action == slfr_pkg::ACT_TICK)
        begin
            result.data_byte      = 8'd0;
            result.payload_length = plen_now;
            if (in_frame_reg)
            begin
                if (idle_inc > {1'b0, cfg.byte_timeout_ticks})
                begin
                    has_result    = 1'b1;
                    result.status = slfr_pkg::ST_BYTE_TMO;
                    hunt_reset    = 1'b1;
                end
                else if (frame_inc > {1'b0, cfg.frame_window_ticks})
                begin
                    has_result    = 1'b1;
                    result.status = slfr_pkg::ST_WINDOW_TMO;
                    hunt_reset    = 1'b1;
                end
                else
                begin
                    idle_ticks_next  = idle_inc[15:0];
                    frame_ticks_next = frame_inc[15:0];
                end
            end
        end
        else if (!in_frame_reg)
        begin
            if (item.rx_byte == cfg.sync_value)
            begin
                has_result       = 1'b1;
                result.position  = 17'd0;
                in_frame_next    = 1'b1;
                byte_count_next  = 17'd1;
                length_word_next = 16'd0;
                crc_low_next     = 8'd0;
                idle_ticks_next  = 16'd0;
                frame_ticks_next = 16'd0;
            end
        end
        else
        begin
            has_result      = 1'b1;
            idle_ticks_next = 16'd0;
            byte_count_next = byte_count_reg + 17'd1;
            if (byte_count_reg == 17'd4)
            begin
                length_word_next = {8'd0, item.rx_byte};
            end
            else if (byte_count_reg == 17'd5)
            begin
                length_word_next      = full_length;
                result.payload_length = full_length;
                if (full_length > cfg.max_payload)
                begin
                    result.status = slfr_pkg::ST_TOO_LONG;
                    hunt_reset    = 1'b1;
                end
            end
            else if (byte_count_reg < 17'(slfr_pkg::HeaderBytes))
            begin
                result.payload_length = 16'd0;
            end
            else
            begin
                result.payload_length = length_word_reg;
                if (byte_count_reg == crc_low_pos)
                begin
                    crc_low_next = item.rx_byte;
                end
                else if (byte_count_reg >= crc_high_pos)
                begin
                    result.frame_crc = {item.rx_byte, crc_low_reg};
                    result.is_last   = 1'b1;
                    hunt_reset       = 1'b1;
                end
            end
        end

        if (hunt_reset)
        begin
            in_frame_next    = 1'b0;
            byte_count_next  = 17'd0;
            length_word_next = 16'd0;
            crc_low_next     = 8'd0;
            idle_ticks_next  = 16'd0;
            frame_ticks_next = 16'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg    <= 1'b0;
            byte_count_reg  <= 17'd0;
            length_word_reg <= 16'd0;
            crc_low_reg     <= 8'd0;
            idle_ticks_reg  <= 16'd0;
            frame_ticks_reg <= 16'd0;
        end
        else if (advance)
        begin
            in_frame_reg    <= in_frame_next;
            byte_count_reg  <= byte_count_next;
            length_word_reg <= length_word_next;
            crc_low_reg     <= crc_low_next;
            idle_ticks_reg  <= idle_ticks_next;
            frame_ticks_reg <= frame_ticks_next;
        end
    end

    // The position counter is zero exactly while hunting.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_frame_reg |-> (byte_count_reg == 17'd0))
        else $error("byte count nonzero while hunting");

    // Any abort or completed frame sends the receiver back to hunting.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && has_result && (result.is_last ||
         result.status != slfr_pkg::ST_FRAME_BYTE)) |=> !in_frame_reg)
        else $error("receiver stayed in frame after abort or last byte");

    // Only a frame byte may carry the last flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        (has_result && result.is_last) |-> (result.status == slfr_pkg::ST_FRAME_BYTE))
        else $error("last flag on an abort report");

    // A byte accepted inside a frame always moves the position on or ends the frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_frame_reg && item.action == slfr_pkg::ACT_BYTE) |-> has_result)
        else $error("frame byte produced no result");

endmodule

// ===== rtl/slfr_out_stage.sv =====
// Result register that holds one result until the consumer takes it.
`timescale 1ns / 1ps

module slfr_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  slfr_pkg::result_t load_data,
    output logic              free,
    output logic              result_valid,
    input  logic              result_ready,
    output slfr_pkg::result_t result
);

    logic              valid_reg;
    logic              valid_next;
    slfr_pkg::result_t data_reg;

    assign free       = !valid_reg || result_ready;
    assign valid_next = load || (valid_reg && !result_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign result_valid = valid_reg;
    assign result       = data_reg;

endmodule

// ===== rtl/sync_length_frame_receiver_unit.sv =====
// Top level of the sync-byte, length-prefixed frame receiver.
//
// Channel  Direction  Signals                                  Content
// item     in         item_valid, item_ready, item             byte or tick request
// result   out        result_valid, result_ready, result       frame byte or abort report
// config   in         cfg_we, cfg_index, cfg_data              register write, no wait
//
// One request per cycle is sustained while the result register is free; a request is
// held in the input register and its result, if any, is loaded into the result register.
// Reset clears the frame state to hunting and loads the register defaults.
// A stalled result holds the result register, and the input register absorbs one
// more request before item_ready drops.
`timescale 1ns / 1ps

module sync_length_frame_receiver_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  slfr_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_ready,
    output slfr_pkg::result_t result,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data
);

    slfr_pkg::cfg_t    cfg_reg;
    logic              held_valid;
    slfr_pkg::item_t   held_item;
    logic              out_free;
    logic              advance;
    logic              has_result;
    slfr_pkg::result_t core_result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_value         <= slfr_pkg::SyncReset;
            cfg_reg.byte_timeout_ticks <= slfr_pkg::TimeoutReset;
            cfg_reg.frame_window_ticks <= slfr_pkg::WindowReset;
            cfg_reg.max_payload        <= slfr_pkg::MaxPayReset;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                slfr_pkg::CFG_SYNC:    cfg_reg.sync_value         <= cfg_data[7:0];
                slfr_pkg::CFG_TIMEOUT: cfg_reg.byte_timeout_ticks <= cfg_data;
                slfr_pkg::CFG_WINDOW:  cfg_reg.frame_window_ticks <= cfg_data;
                slfr_pkg::CFG_MAXPAY:  cfg_reg.max_payload        <= cfg_data;
                default:               cfg_reg                    <= cfg_reg;
            endcase
        end
    end

    assign advance = held_valid && out_free;

    slfr_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .take       (advance),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    slfr_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .advance    (advance),
        .item       (held_item),
        .has_result (has_result),
        .result     (core_result)
    );

    slfr_out_stage u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (advance && has_result),
        .load_data    (core_result),
        .free         (out_free),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
